// File: design/utu_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; every other design file imports this package.
package utu_pkg;

  localparam int JOB_UNITS   = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] UNIT_REPL = 16'hFFFD;
  localparam logic [15:0] UNIT_BOM  = 16'hFEFF;

  // Configuration register indexes (byte address 4*i)
  localparam logic REG_LITTLE_ENDIAN = 1'b0;
  localparam logic REG_ADD_BOM       = 1'b1;

  // One decoded input byte: the UTF-16 units it produces, in output order
  typedef struct packed {
    logic [JOB_UNITS-1:0][15:0] units;
    logic [2:0]                 cnt;
    logic                       last;
  } job_t;

endpackage

// File: design/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder: APB registers and the
// front end, job queue and byte serializer. Depends on utu_pkg, utu_front, utu_fifo, utu_back.

// The block takes one UTF-8 byte per cycle on the slave stream while the queue has room, and
// sends UTF-16 bytes on the master stream, one byte per cycle while m_tready is high, each
// 16-bit unit in the byte order of little_endian. Each input byte is decoded in the cycle it
// is accepted and its output units go into a QUEUE_DEPTH-entry job queue; the serializer sends
// each unit as two bytes. An ASCII byte thus yields two output bytes, a four-byte sequence four,
// and a byte that triggers a resync up to eight. The sustained rate is therefore set by the
// serializer's output. m_tuser marks the last byte caused by an input byte and m_tlast the last
// byte of a string. Registers: little_endian at 0x0, add_bom at 0x4.
module utf8_to_utf16_transcoder #(
  parameter int QUEUE_DEPTH = utu_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tuser,   // [0] run_last
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import utu_pkg::*;

  logic little_endian;
  logic add_bom;
  logic reg_idx;
  logic accept;
  logic push, pop, full, head_valid;
  job_t job, head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      little_endian <= 1'b0;
      add_bom       <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_LITTLE_ENDIAN: little_endian <= pwdata[0];
        REG_ADD_BOM:       add_bom       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LITTLE_ENDIAN: prdata = {31'b0, little_endian};
      REG_ADD_BOM:       prdata = {31'b0, add_bom};
      default:           prdata = 32'b0;
    endcase
  end

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  utu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .add_bom (add_bom),
    .accept  (accept),
    .in_byte (s_tdata),
    .in_last (s_tlast),
    .push    (push),
    .job     (job)
  );

  utu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job),
    .full  (full),
    .pop   (pop),
    .rdata (head),
    .valid (head_valid)
  );

  utu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .little_endian (little_endian),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast)
  );

endmodule

// File: design/utu_front.sv
// Front end: UTF-8 sequence decoder that turns each input byte into a job of UTF-16 units.
// Depends on utu_pkg.
module utu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          add_bom,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          push,
  output utu_pkg::job_t job
);
  import utu_pkg::*;

  typedef struct packed {
    logic [1:0]  n;
    logic [15:0] hi;
    logic [15:0] lo;
  } code_units_t;

  function automatic code_units_t code_units(input logic [20:0] c);
    code_units_t r;
    logic [20:0] v;
    v = c - 21'h010000;
    r.n  = 2'd1;
    r.hi = UNIT_REPL;
    r.lo = 16'h0000;
    if (c <= 21'h00D7FF || (c >= 21'h00E000 && c <= 21'h00FFFF)) begin
      r.hi = c[15:0];
    end else if (c >= 21'h010000 && c <= 21'h10FFFF) begin
      r.n  = 2'd2;
      r.hi = 16'hD800 + {6'b0, v[19:10]};
      r.lo = 16'hDC00 + {6'b0, v[9:0]};
    end
    return r;
  endfunction

  logic [20:0] code_accum, code_accum_next;
  logic [1:0]  bytes_needed, bytes_needed_next;
  logic [1:0]  bytes_held, bytes_held_next;
  logic        at_string_start;

  logic [1:0]  lead_n;
  logic [4:0]  lead_bits;
  logic [20:0] acc_cat;
  logic [1:0]  n_repl;
  logic [1:0]  tail_n;
  logic [15:0] tail0, tail1;
  logic        do_lead;
  code_units_t cu;

  logic [5:0]       cand_en;
  logic [5:0][15:0] cand;

  always_comb begin
    lead_n    = 2'd0;
    lead_bits = 5'd0;
    if (in_byte[7:3] == 5'b11110) begin
      lead_n    = 2'd3;
      lead_bits = {2'b00, in_byte[2:0]};
    end else if (in_byte[7:4] == 4'b1110) begin
      lead_n    = 2'd2;
      lead_bits = {1'b0, in_byte[3:0]};
    end else if (in_byte[7:5] == 3'b110) begin
      lead_n    = 2'd1;
      lead_bits = in_byte[4:0];
    end
  end

  assign acc_cat = {code_accum[14:0], in_byte[5:0]};

  always_comb begin
    n_repl            = 2'd0;
    tail_n            = 2'd0;
    tail0             = 16'h0000;
    tail1             = 16'h0000;
    do_lead           = 1'b0;
    code_accum_next   = code_accum;
    bytes_needed_next = bytes_needed;
    bytes_held_next   = bytes_held;
    cu                = code_units(acc_cat);
    if (bytes_needed != 2'd0) begin
      if (in_byte[7:6] == 2'b10) begin
        if (bytes_needed == 2'd1) begin
          tail_n            = cu.n;
          tail0             = cu.hi;
          tail1             = cu.lo;
          code_accum_next   = '0;
          bytes_needed_next = 2'd0;
          bytes_held_next   = 2'd0;
        end else begin
          code_accum_next   = acc_cat;
          bytes_needed_next = bytes_needed - 2'd1;
          bytes_held_next   = bytes_held + 2'd1;
          // truncated string: one replacement for the lead and each held byte
          if (in_last) begin
            n_repl = bytes_held + 2'd2;
          end
        end
      end else begin
        // resync: replace lead and held bytes, then retry this byte as a lead
        n_repl            = bytes_held + 2'd1;
        code_accum_next   = '0;
        bytes_needed_next = 2'd0;
        bytes_held_next   = 2'd0;
        do_lead           = 1'b1;
      end
    end else begin
      do_lead = 1'b1;
    end

    if (do_lead) begin
      if (!in_byte[7]) begin
        tail_n = 2'd1;
        tail0  = {8'h00, in_byte};
      end else if (lead_n != 2'd0 && !in_last) begin
        code_accum_next   = {16'b0, lead_bits};
        bytes_needed_next = lead_n;
        bytes_held_next   = 2'd0;
      end else begin
        tail_n = 2'd1;
        tail0  = UNIT_REPL;
      end
    end

    if (in_last) begin
      code_accum_next   = '0;
      bytes_needed_next = 2'd0;
      bytes_held_next   = 2'd0;
    end
  end

  // Candidate units in output order: mark, up to three replacements, tail
  always_comb begin
    cand    = {tail1, tail0, UNIT_REPL, UNIT_REPL, UNIT_REPL, UNIT_BOM};
    cand_en = {tail_n == 2'd2, tail_n != 2'd0, n_repl == 2'd3, n_repl >= 2'd2,
               n_repl != 2'd0, at_string_start && add_bom};
  end

  // Pack enabled candidates into consecutive slots
  always_comb begin
    job = '0;
    for (int k = 0; k < 6; k++) begin
      if (cand_en[k] && job.cnt != 3'(JOB_UNITS)) begin
        job.units[job.cnt[1:0]] = cand[k];
        job.cnt                 = job.cnt + 3'd1;
      end
    end
    job.last = in_last;
  end

  assign push = accept && (job.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      code_accum      <= '0;
      bytes_needed    <= 2'd0;
      bytes_held      <= 2'd0;
      at_string_start <= 1'b1;
    end else if (accept) begin
      code_accum      <= code_accum_next;
      bytes_needed    <= bytes_needed_next;
      bytes_held      <= bytes_held_next;
      at_string_start <= in_last;
    end
  end

endmodule

// File: design/utu_fifo.sv
// Job queue between the decoder front end and the byte serializer.
// Depends on utu_pkg; DEPTH must be a power of two, at least 2.
module utu_fifo #(
  parameter int DEPTH = utu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  utu_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output utu_pkg::job_t rdata,
  output logic          valid
);
  import utu_pkg::*;

  localparam int AW = $clog2(DEPTH);

  job_t        mem [DEPTH];
  logic [AW:0] wptr, rptr;

  assign valid = (wptr != rptr);
  assign full  = (wptr[AW] != rptr[AW]) && (wptr[AW-1:0] == rptr[AW-1:0]);
  assign rdata = mem[rptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

endmodule

// File: design/utu_back.sv
// Back end: serializes queued UTF-16 units into bytes through an output register.
// Depends on utu_pkg.
module utu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          little_endian,
  input  logic          head_valid,
  input  utu_pkg::job_t head,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,   // [7:0] out_byte
  output logic          m_tuser,   // [0] run_last
  output logic          m_tlast
);
  import utu_pkg::*;

  logic [2:0]  idx;
  logic [15:0] unit;
  logic [7:0]  byte_sel;
  logic [3:0]  last_idx;
  logic        run_end;
  logic        load;

  assign unit     = head.units[idx[2:1]];
  assign byte_sel = (idx[0] != little_endian) ? unit[7:0] : unit[15:8];
  assign last_idx = {head.cnt, 1'b0} - 4'd1;
  assign run_end  = ({1'b0, idx} == last_idx);
  assign load     = head_valid && (!m_tvalid || m_tready);
  assign pop      = load && run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 3'd0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      idx      <= run_end ? 3'd0 : idx + 3'd1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= byte_sel;
      m_tuser <= run_end;
      m_tlast <= run_end && head.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_empty_job: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> head.cnt != 3'd0)
    else $error("empty job reached the serializer");

  a_idx_wraps: assert property (@(posedge clk) disable iff (rst)
    (load && run_end) |=> idx == 3'd0)
    else $error("byte index did not wrap after the last byte of a job");

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> {1'b0, idx} <= last_idx)
    else $error("byte index ran past the end of the job");

  a_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("string end without run end");
`endif

endmodule

// File: tb/sv/utf16_stream_checker.sv
// Checker for the UTF-8 to UTF-16 transcoder: watches the register port and both streams,
// predicts every UTF-16 output byte and compares it with what the block sends.
// Depends on utu_pkg for the register indexes and the special code units.
module utf16_stream_checker
  import utu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [7:0] out_byte
  input  logic        m_tuser,   // [0] run_last
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          err_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       str_end;
  } utf16_byte_t;

  logic        le_mode    = 1'b0;
  logic        bom_mode   = 1'b0;
  logic [20:0] cp_acc     = '0;
  logic [1:0]  cont_left  = '0;
  logic [1:0]  cont_taken = '0;
  logic        str_start  = 1'b1;

  utf16_byte_t utf16_due_q[$];
  utf16_byte_t word_bytes_q[$];

  initial begin
    err_count = 0;
    pending   = 0;
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // a single input word never yields more than eight bytes
  function automatic void emit_byte(input logic [7:0] b);
    utf16_byte_t w;
    w.data     = b;
    w.run_last = 1'b0;
    w.str_end  = 1'b0;
    if (word_bytes_q.size() < 8) word_bytes_q.push_back(w);
  endfunction

  function automatic void emit_unit(input logic [15:0] u);
    if (le_mode) begin
      emit_byte(u[7:0]);
      emit_byte(u[15:8]);
    end else begin
      emit_byte(u[15:8]);
      emit_byte(u[7:0]);
    end
  endfunction

  function automatic void emit_code(input logic [20:0] c);
    logic [20:0] v;
    if (c <= 21'h00D7FF || (c >= 21'h00E000 && c <= 21'h00FFFF)) begin
      emit_unit(c[15:0]);
    end else if (c >= 21'h010000 && c <= 21'h10FFFF) begin
      v = c - 21'h010000;
      emit_unit(16'hD800 + {6'd0, v[19:10]});
      emit_unit(16'hDC00 + {6'd0, v[9:0]});
    end else begin
      emit_unit(UNIT_REPL);
    end
  endfunction

  function automatic void take_lead(input logic [7:0] b, input logic last);
    logic [1:0] n;
    logic [4:0] bits;
    n    = 2'd0;
    bits = '0;
    if (!b[7]) begin
      emit_code({13'd0, b});
      return;
    end
    casez (b)
      8'b11110???: begin
        n    = 2'd3;
        bits = {2'b00, b[2:0]};
      end
      8'b1110????: begin
        n    = 2'd2;
        bits = {1'b0, b[3:0]};
      end
      8'b110?????: begin
        n    = 2'd1;
        bits = b[4:0];
      end
      default: ;
    endcase
    // bad lead, or a multi-byte lead that ends the string
    if (n == 2'd0 || last) begin
      emit_unit(UNIT_REPL);
    end else begin
      cp_acc     = {16'd0, bits};
      cont_left  = n;
      cont_taken = 2'd0;
    end
  endfunction

  function automatic void predict_utf16(input logic [7:0] b, input logic last);
    int i;
    utf16_byte_t w;
    word_bytes_q.delete();
    if (str_start && bom_mode) emit_unit(UNIT_BOM);
    str_start = 1'b0;
    if (cont_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        cp_acc    = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          emit_code(cp_acc);
          cp_acc     = '0;
          cont_taken = 2'd0;
        end else begin
          cont_taken = cont_taken + 2'd1;
          if (last) begin
            for (i = 0; i <= cont_taken; i++) emit_unit(UNIT_REPL);
          end
        end
      end else begin
        // missing continuation: replace lead and taken bytes, then resync on this byte
        for (i = 0; i <= cont_taken; i++) emit_unit(UNIT_REPL);
        cp_acc     = '0;
        cont_left  = 2'd0;
        cont_taken = 2'd0;
        take_lead(b, last);
      end
    end else begin
      take_lead(b, last);
    end
    if (last) begin
      cp_acc     = '0;
      cont_left  = 2'd0;
      cont_taken = 2'd0;
      str_start  = 1'b1;
    end
    for (i = 0; i < word_bytes_q.size(); i++) begin
      w = word_bytes_q[i];
      if (i == word_bytes_q.size() - 1) begin
        w.run_last = 1'b1;
        w.str_end  = last;
      end
      utf16_due_q.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    utf16_byte_t due;
    if (rst) begin
      le_mode    = 1'b0;
      bom_mode   = 1'b0;
      cp_acc     = '0;
      cont_left  = 2'd0;
      cont_taken = 2'd0;
      str_start  = 1'b1;
      utf16_due_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          {REG_LITTLE_ENDIAN, 2'b00}: le_mode  = pwdata[0];
          {REG_ADD_BOM, 2'b00}:       bom_mode = pwdata[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_utf16(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (utf16_due_q.size() == 0) begin
          report($sformatf("unexpected word %02h user %0b last %0b",
                           m_tdata, m_tuser, m_tlast));
        end else begin
          due = utf16_due_q.pop_front();
          if (m_tdata !== due.data)
            report($sformatf("byte %02h, expected %02h", m_tdata, due.data));
          if (m_tuser !== due.run_last)
            report($sformatf("run_last %0b, expected %0b on byte %02h",
                             m_tuser, due.run_last, due.data));
          if (m_tlast !== due.str_end)
            report($sformatf("string_end %0b, expected %0b on byte %02h",
                             m_tlast, due.str_end, due.data));
        end
      end
    end
    pending <= utf16_due_q.size();
  end

endmodule

// File: tb/sv/tb.sv
// Top of the transcoder testbench: clock, reset, register writes, UTF-8 stimulus and
// receiver back-pressure, with the verdict. Depends on utu_pkg, the transcoder RTL and
// utf16_stream_checker.
module tb;
  import utu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 36;
  // per random phase, bit p: byte order and byte order mark settings
  localparam logic [3:0] LE_PLAN  = 4'b0101;
  localparam logic [3:0] BOM_PLAN = 4'b0011;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;  // [7:0] in_byte
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [7:0] out_byte
  logic        m_tuser;           // [0] run_last
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = 3'd0;
  logic [31:0] pwdata   = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  logic        rx_hold_req = 1'b0;
  int          err_count;
  int          pending;
  int          cycle_count = 0;

  // bit 8 marks the final byte of a string
  logic [8:0]  utf8_q[$];

  utf8_to_utf16_transcoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  utf16_stream_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .err_count (err_count),
    .pending   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : rx_side
    int  hold;
    bit  served;
    bit  calm;
    served = 1'b0;
    calm   = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req && !served) begin
        // hold off long enough for the job queue to fill and stall the input
        served = 1'b1;
        m_tready <= 1'b0;
        for (hold = 0; hold < LONG_HOLD; hold++) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        if (!rx_hold_req) served = 1'b0;
        if ($urandom_range(0, 63) == 0) calm = !calm;
        hold = calm ? 0 : gap_cycles();
        if (hold > 0) begin
          m_tready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {31'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic play_words(input bit gappy);
    int k;
    int gap;
    for (k = 0; k < utf8_q.size(); k++) begin
      s_tdata  <= utf8_q[k][7:0];
      s_tlast  <= utf8_q[k][8];
      s_tvalid <= 1'b1;
      do @(posedge clk); while (!s_tready);
      gap = gappy ? gap_cycles() : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // drop valid, wait for every expected word, then let the serializer go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // push the lead and the first keep continuation bytes of a sequence
  task automatic add_code(input logic [20:0] cp, input int ncont, input int keep);
    int j;
    case (ncont)
      0:       utf8_q.push_back({2'b00, cp[6:0]});
      1:       utf8_q.push_back({4'b0110, cp[10:6]});
      2:       utf8_q.push_back({5'b01110, cp[15:12]});
      default: utf8_q.push_back({6'b011110, cp[20:18]});
    endcase
    for (j = ncont - 1; j >= ncont - keep; j--) utf8_q.push_back({3'b010, cp[6*j +: 6]});
  endtask

  task automatic build_string();
    int          nchars;
    int          c;
    int          kind;
    int          n;
    logic [20:0] cp;
    logic [8:0]  w;
    utf8_q.delete();
    nchars = $urandom_range(1, 8);
    for (c = 0; c < nchars; c++) begin
      kind = $urandom_range(0, 19);
      cp   = 21'($urandom);
      if (kind < 8) begin
        add_code(cp & 21'h00007F, 0, 0);
      end else if (kind < 11) begin
        add_code(cp, 1, 1);
      end else if (kind < 14) begin
        if ($urandom_range(0, 7) == 0) cp = 21'h00D800 | (cp & 21'h0007FF);
        add_code(cp, 2, 2);
      end else if (kind < 17) begin
        // mostly valid supplementary planes, sometimes any 21-bit value
        if ($urandom_range(0, 7) != 0) cp = 21'h010000 + (cp & 21'h0FFFFF);
        add_code(cp, 3, 3);
      end else if (kind < 19) begin
        n = $urandom_range(1, 3);
        add_code(cp, n, $urandom_range(0, n - 1));
      end else begin
        utf8_q.push_back({1'b0, 8'($urandom)});
      end
    end
    w = utf8_q.pop_back();
    utf8_q.push_back({1'b1, w[7:0]});
  endtask

  initial begin : stimulus
    int p;
    int k;
    int sent;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed strings at reset settings: ASCII extremes, two-, three- and four-byte
    // sequences, surrogate and out-of-range code points, bad leads, resync after two
    // taken continuations, early end mid-sequence, lone multi-byte lead ending a string
    utf8_q = '{9'h000, 9'h0C2, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC,
               9'h0F0, 9'h09F, 9'h098, 9'h180,
               9'h07F, 9'h0ED, 9'h0A0, 9'h180,
               9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
               9'h0FF, 9'h080, 9'h0F0, 9'h09F, 9'h098, 9'h0F0, 9'h19F,
               9'h1C2};
    play_words(1'b1);
    settle();

    for (p = 0; p < 4; p++) begin
      write_reg({REG_LITTLE_ENDIAN, 2'b00}, LE_PLAN[p]);
      write_reg({REG_ADD_BOM, 2'b00}, BOM_PLAN[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_string();
        sent += utf8_q.size();
        play_words($urandom_range(0, 3) != 0);
      end
      if (p == 1) begin
        // back-to-back ASCII while the receiver holds off
        rx_hold_req <= 1'b1;
        utf8_q.delete();
        for (k = 0; k < 32; k++) utf8_q.push_back({1'b0, 1'b0, 7'($urandom)});
        utf8_q.push_back({1'b1, 8'h0A});
        play_words(1'b0);
        rx_hold_req <= 1'b0;
      end
      settle();
    end

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
